FILE: design/isd_pkg.sv
package isd_pkg;

  localparam int unsigned PositionBitsDef = 32;
  localparam int unsigned HdrLen = 30;
  localparam int unsigned WinLen = 20;

  localparam logic [2:0] FMT_PNG  = 3'd0;
  localparam logic [2:0] FMT_JPEG = 3'd1;
  localparam logic [2:0] FMT_GIF  = 3'd2;
  localparam logic [2:0] FMT_WEBP = 3'd3;
  localparam logic [2:0] FMT_BMP  = 3'd4;
  localparam logic [2:0] FMT_ISO  = 3'd5;
  localparam logic [2:0] FMT_TIFF = 3'd6;
  localparam logic [2:0] FMT_ICO  = 3'd7;

  localparam logic [15:0] TIFF_TAG_WIDTH  = 16'h0100;
  localparam logic [15:0] TIFF_TAG_HEIGHT = 16'h0101;
  localparam logic [15:0] TIFF_TYPE_SHORT = 16'd3;

  typedef logic [HdrLen-1:0][7:0] hdr_t;

  typedef struct packed {
    logic        done;
    logic [15:0] width;
    logic [15:0] height;
  } jpg_stat_t;

  typedef struct packed {
    logic        done;
    logic [31:0] width;
    logic [31:0] height;
  } size_stat_t;

endpackage

FILE: design/isd_jpeg.sv
module isd_jpeg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                clr_i,
  input  logic [7:0]          data_i,
  output isd_pkg::jpg_stat_t  stat_o
);

  localparam logic [3:0] J_SOI0   = 4'd0;
  localparam logic [3:0] J_SOI1   = 4'd1;
  localparam logic [3:0] J_SCAN   = 4'd2;
  localparam logic [3:0] J_MARK   = 4'd3;
  localparam logic [3:0] J_LEN_HI = 4'd4;
  localparam logic [3:0] J_LEN_LO = 4'd5;
  localparam logic [3:0] J_SKIP   = 4'd6;
  localparam logic [3:0] J_FRAME  = 4'd7;
  localparam logic [3:0] J_DONE   = 4'd8;
  localparam logic [3:0] J_DEAD   = 4'd9;

  logic [3:0]  state_q, state_d;
  logic [15:0] skip_q, skip_d;
  logic        frame_q, frame_d;
  logic        done_q, done_d;
  logic [15:0] w_q, w_d, h_q, h_d;
  logic [15:0] seg;

  always_comb begin
    state_d = state_q;
    skip_d  = skip_q;
    frame_d = frame_q;
    done_d  = done_q;
    w_d     = w_q;
    h_d     = h_q;
    seg     = {skip_q[15:8], data_i};
    case (state_q)
      J_SOI0: state_d = (data_i == 8'hFF) ? J_SOI1 : J_DEAD;
      J_SOI1: state_d = (data_i == 8'hD8) ? J_SCAN : J_DEAD;
      J_SCAN: if (data_i == 8'hFF) state_d = J_MARK;
      J_MARK: begin
        if (data_i == 8'hFF) begin
          state_d = J_MARK;
        end else if (data_i == 8'hD8 || data_i == 8'h01 ||
                     (data_i >= 8'hD0 && data_i <= 8'hD7)) begin
          state_d = J_SCAN;
        end else begin
          frame_d = (data_i >= 8'hC0) && (data_i <= 8'hCF) && (data_i != 8'hC4) &&
                    (data_i != 8'hC8) && (data_i != 8'hCC);
          state_d = J_LEN_HI;
        end
      end
      J_LEN_HI: begin
        skip_d  = {data_i, 8'h00};
        state_d = J_LEN_LO;
      end
      J_LEN_LO: begin
        if (seg < 16'd2) begin
          state_d = J_DEAD;
        end else if (frame_q) begin
          skip_d  = '0;
          w_d     = '0;
          h_d     = '0;
          state_d = J_FRAME;
        end else begin
          skip_d  = seg - 16'd2;
          state_d = (seg == 16'd2) ? J_SCAN : J_SKIP;
        end
      end
      J_SKIP: begin
        skip_d = skip_q - 16'd1;
        if (skip_d == '0) state_d = J_SCAN;
      end
      J_FRAME: begin
        // precision, height hi/lo, width hi/lo
        case (skip_q[2:0])
          3'd1:    h_d[15:8] = data_i;
          3'd2:    h_d[7:0]  = data_i;
          3'd3:    w_d[15:8] = data_i;
          3'd4:    w_d[7:0]  = data_i;
          default: ;
        endcase
        if (skip_q >= 16'd4) begin
          done_d  = 1'b1;
          state_d = J_DONE;
        end else begin
          skip_d = skip_q + 16'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= J_SOI0;
      skip_q  <= '0;
      frame_q <= 1'b0;
      done_q  <= 1'b0;
      w_q     <= '0;
      h_q     <= '0;
    end else if (en_i) begin
      if (clr_i) begin
        state_q <= J_SOI0;
        skip_q  <= '0;
        frame_q <= 1'b0;
        done_q  <= 1'b0;
        w_q     <= '0;
        h_q     <= '0;
      end else begin
        state_q <= state_d;
        skip_q  <= skip_d;
        frame_q <= frame_d;
        done_q  <= done_d;
        w_q     <= w_d;
        h_q     <= h_d;
      end
    end
  end

  assign stat_o = '{done: done_d, width: w_d, height: h_d};

endmodule

FILE: design/isd_tiff.sv
module isd_tiff #(
  parameter int unsigned PositionBits = isd_pkg::PositionBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    clr_i,
  input  logic [7:0]              data_i,
  input  logic [PositionBits-1:0] pos_i,
  input  logic [7:0][7:0]         hdr_i,
  output isd_pkg::size_stat_t     stat_o
);

  localparam int unsigned CmpBits = (PositionBits > 32) ? PositionBits : 32;

  localparam logic [2:0] T_HDR   = 3'd0;
  localparam logic [2:0] T_SEEK  = 3'd1;
  localparam logic [2:0] T_COUNT = 3'd2;
  localparam logic [2:0] T_ENTRY = 3'd3;
  localparam logic [2:0] T_DONE  = 3'd4;
  localparam logic [2:0] T_DEAD  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [31:0]       off_q, off_d;
  logic [15:0]       left_q, left_d;
  logic [1:0]        tags_q, tags_d;
  logic              little_q, little_d;
  logic [3:0]        idx_q, idx_d;
  logic [11:0][7:0]  ent_q, ent_d;
  logic              done_q, done_d;
  logic [31:0]       w_q, w_d, h_q, h_d;
  logic [15:0]       tag, typ;
  logic [31:0]       val, hoff;
  logic              is_ii, is_mm;

  always_comb begin
    state_d  = state_q;
    off_d    = off_q;
    left_d   = left_q;
    tags_d   = tags_q;
    little_d = little_q;
    idx_d    = idx_q;
    ent_d    = ent_q;
    done_d   = done_q;
    w_d      = w_q;
    h_d      = h_q;
    is_ii    = (hdr_i[0] == 8'h49) && (hdr_i[1] == 8'h49) &&
               (hdr_i[2] == 8'h2A) && (hdr_i[3] == 8'h00);
    is_mm    = (hdr_i[0] == 8'h4D) && (hdr_i[1] == 8'h4D) &&
               (hdr_i[2] == 8'h00) && (hdr_i[3] == 8'h2A);
    hoff     = is_ii ? {hdr_i[7], hdr_i[6], hdr_i[5], hdr_i[4]}
                     : {hdr_i[4], hdr_i[5], hdr_i[6], hdr_i[7]};
    if (idx_q < 4'd12) ent_d[idx_q] = data_i;
    tag = little_q ? {ent_d[1], ent_d[0]} : {ent_d[0], ent_d[1]};
    typ = little_q ? {ent_d[3], ent_d[2]} : {ent_d[2], ent_d[3]};
    if (typ == isd_pkg::TIFF_TYPE_SHORT) begin
      val = little_q ? {16'h0, ent_d[9], ent_d[8]} : {16'h0, ent_d[8], ent_d[9]};
    end else begin
      val = little_q ? {ent_d[11], ent_d[10], ent_d[9], ent_d[8]}
                     : {ent_d[8], ent_d[9], ent_d[10], ent_d[11]};
    end
    case (state_q)
      T_HDR: begin
        ent_d = ent_q;
        if (pos_i == PositionBits'(7)) begin
          if (!is_ii && !is_mm) begin
            state_d = T_DEAD;
          end else begin
            little_d = is_ii;
            off_d    = hoff;
            state_d  = (hoff < 32'd8) ? T_DEAD : T_SEEK;
          end
        end
      end
      T_SEEK: begin
        ent_d = ent_q;
        if (CmpBits'(pos_i) == CmpBits'(off_q)) begin
          ent_d[0] = data_i;
          state_d  = T_COUNT;
        end
      end
      T_COUNT: begin
        ent_d    = ent_q;
        ent_d[1] = data_i;
        left_d   = little_q ? {data_i, ent_q[0]} : {ent_q[0], data_i};
        idx_d    = '0;
        state_d  = (left_d != '0) ? T_ENTRY : T_DEAD;
      end
      T_ENTRY: begin
        idx_d = idx_q + 4'd1;
        if (idx_q == 4'd11) begin
          idx_d = '0;
          if (tag == isd_pkg::TIFF_TAG_WIDTH || tag == isd_pkg::TIFF_TAG_HEIGHT) begin
            if (tag == isd_pkg::TIFF_TAG_WIDTH) w_d = val;
            else h_d = val;
            tags_d = tags_q + 2'd1;
          end
          if (tags_d >= 2'd2) begin
            done_d  = 1'b1;
            state_d = T_DONE;
          end else begin
            left_d = left_q - 16'd1;
            if (left_d == '0) state_d = T_DEAD;
          end
        end
      end
      default: ent_d = ent_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= T_HDR;
      off_q    <= '0;
      left_q   <= '0;
      tags_q   <= '0;
      little_q <= 1'b0;
      idx_q    <= '0;
      done_q   <= 1'b0;
      w_q      <= '0;
      h_q      <= '0;
    end else if (en_i) begin
      if (clr_i) begin
        state_q  <= T_HDR;
        off_q    <= '0;
        left_q   <= '0;
        tags_q   <= '0;
        little_q <= 1'b0;
        idx_q    <= '0;
        done_q   <= 1'b0;
        w_q      <= '0;
        h_q      <= '0;
      end else begin
        state_q  <= state_d;
        off_q    <= off_d;
        left_q   <= left_d;
        tags_q   <= tags_d;
        little_q <= little_d;
        idx_q    <= idx_d;
        done_q   <= done_d;
        w_q      <= w_d;
        h_q      <= h_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) ent_q <= ent_d;
  end

  assign stat_o = '{done: done_d, width: w_d, height: h_d};

endmodule

FILE: design/isd_judge.sv
module isd_judge #(
  parameter int unsigned PositionBits = isd_pkg::PositionBitsDef
) (
  input  isd_pkg::hdr_t           hdr_i,
  input  logic [PositionBits-1:0] pos_i,
  input  isd_pkg::jpg_stat_t      jpeg_i,
  input  isd_pkg::size_stat_t     iso_i,
  input  isd_pkg::size_stat_t     tiff_i,
  output logic                    found_o,
  output logic [2:0]              format_o,
  output logic [31:0]             width_o,
  output logic [31:0]             height_o
);

  isd_pkg::hdr_t b;
  logic          riff, is_png, is_gif, is_bmp, is_iso, is_ico;
  logic          vp8x, vp8l, vp8;
  logic [31:0]   lbits, bx, by;

  assign b = hdr_i;

  always_comb begin
    is_png = (pos_i >= PositionBits'(23)) &&
             ({b[0], b[1], b[2], b[3]} == 32'h89504E47) &&
             ({b[4], b[5], b[6], b[7]} == 32'h0D0A1A0A) &&
             ({b[12], b[13], b[14], b[15]} == 32'h49484452);
    is_gif = (pos_i >= PositionBits'(9)) && ({b[0], b[1], b[2], b[3]} == 32'h47494638);
    riff   = (pos_i >= PositionBits'(29)) && ({b[0], b[1], b[2], b[3]} == 32'h52494646) &&
             ({b[8], b[9], b[10], b[11]} == 32'h57454250);
    vp8x   = riff && ({b[12], b[13], b[14], b[15]} == 32'h56503858);
    vp8l   = riff && ({b[12], b[13], b[14], b[15]} == 32'h5650384C) && (b[20] == 8'h2F);
    vp8    = riff && ({b[12], b[13], b[14], b[15]} == 32'h56503820) &&
             (b[23] == 8'h9D) && (b[24] == 8'h01) && (b[25] == 8'h2A);
    is_bmp = (pos_i >= PositionBits'(25)) && (b[0] == 8'h42) && (b[1] == 8'h4D);
    is_iso = (pos_i >= PositionBits'(11)) && ({b[4], b[5], b[6], b[7]} == 32'h66747970) &&
             iso_i.done && (iso_i.width != '0) && !iso_i.width[31] &&
             (iso_i.height != '0) && !iso_i.height[31];
    is_ico = (pos_i >= PositionBits'(21)) && (b[0] == 8'h00) && (b[1] == 8'h00) &&
             (b[2] == 8'h01 || b[2] == 8'h02) && (b[3] == 8'h00) &&
             ({b[5], b[4]} != 16'h0);
    lbits  = {b[24], b[23], b[22], b[21]};
    bx     = {b[21], b[20], b[19], b[18]};
    by     = {b[25], b[24], b[23], b[22]};

    found_o  = 1'b1;
    format_o = isd_pkg::FMT_PNG;
    width_o  = '0;
    height_o = '0;
    if (is_png) begin
      width_o  = {b[16], b[17], b[18], b[19]};
      height_o = {b[20], b[21], b[22], b[23]};
    end else if (jpeg_i.done) begin
      format_o = isd_pkg::FMT_JPEG;
      width_o  = {16'h0, jpeg_i.width};
      height_o = {16'h0, jpeg_i.height};
    end else if (is_gif) begin
      format_o = isd_pkg::FMT_GIF;
      width_o  = {16'h0, b[7], b[6]};
      height_o = {16'h0, b[9], b[8]};
    end else if (vp8x) begin
      format_o = isd_pkg::FMT_WEBP;
      width_o  = {8'h0, b[22], b[21], b[20]} + 32'd1;
      height_o = {8'h0, b[25], b[24], b[23]} + 32'd1;
    end else if (vp8l) begin
      format_o = isd_pkg::FMT_WEBP;
      width_o  = {18'h0, lbits[13:0]} + 32'd1;
      height_o = {18'h0, lbits[27:14]} + 32'd1;
    end else if (vp8) begin
      format_o = isd_pkg::FMT_WEBP;
      width_o  = {18'h0, b[27][5:0], b[26]};
      height_o = {18'h0, b[29][5:0], b[28]};
    end else if (is_bmp) begin
      format_o = isd_pkg::FMT_BMP;
      width_o  = bx[31] ? (32'd0 - bx) : bx;
      height_o = by[31] ? (32'd0 - by) : by;
    end else if (is_iso) begin
      format_o = isd_pkg::FMT_ISO;
      width_o  = iso_i.width;
      height_o = iso_i.height;
    end else if (tiff_i.done) begin
      format_o = isd_pkg::FMT_TIFF;
      width_o  = tiff_i.width;
      height_o = tiff_i.height;
    end else if (is_ico) begin
      format_o = isd_pkg::FMT_ICO;
      width_o  = (b[6] != 8'h0) ? {24'h0, b[6]} : 32'd256;
      height_o = (b[7] != 8'h0) ? {24'h0, b[7]} : 32'd256;
    end else begin
      found_o = 1'b0;
    end
  end

endmodule

FILE: design/image_header_dimension_sniffer_core.sv
// A beat is held in the input register; when the last beat of a file leaves it,
// the result is loaded into the output register.
// Throughput: one byte per cycle, limited only by a result not yet taken.
// Reset (rst_ni low, asynchronous) clears all walkers and positions; the block
// also returns to that state by itself after each file's last byte.
module image_header_dimension_sniffer_core #(
  parameter int unsigned PositionBits = isd_pkg::PositionBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [2:0]  format_o,
  output logic [31:0] width_o,
  output logic [31:0] height_o
);

  localparam int unsigned WinLen = isd_pkg::WinLen;
  localparam logic [PositionBits-1:0] PosMax = '1;

  logic                     in_valid_q, in_last_q;
  logic [7:0]               in_byte_q;
  logic                     advance, clr;
  logic [PositionBits-1:0]  pos_q;
  isd_pkg::hdr_t            hdr_q, hdr_d;
  logic [WinLen-1:0][7:0]   win_q, win_d;
  isd_pkg::size_stat_t      iso_q, iso_d;
  isd_pkg::jpg_stat_t       jpeg_stat;
  isd_pkg::size_stat_t      tiff_stat;
  logic                     j_found;
  logic [2:0]               j_format;
  logic [31:0]              j_width, j_height;
  logic                     out_valid_q;

  assign advance    = in_valid_q && (!in_last_q || !out_valid_q || out_ready_i);
  assign clr        = advance && in_last_q;
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_i;
    end
  end

  always_comb begin
    for (int i = 0; i < isd_pkg::HdrLen; i++) begin
      hdr_d[i] = (pos_q == PositionBits'(i)) ? in_byte_q : hdr_q[i];
    end
    win_d = {in_byte_q, win_q[WinLen-1:1]};
    iso_d = iso_q;
    if (pos_q >= PositionBits'(WinLen - 1) && !iso_q.done &&
        {win_d[0], win_d[1], win_d[2], win_d[3]} == 32'h69737065) begin
      iso_d.done   = 1'b1;
      iso_d.width  = {win_d[8], win_d[9], win_d[10], win_d[11]};
      iso_d.height = {win_d[12], win_d[13], win_d[14], win_d[15]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      iso_q <= '0;
    end else if (advance) begin
      if (clr) begin
        pos_q <= '0;
        iso_q <= '0;
      end else begin
        pos_q <= (pos_q == PosMax) ? PosMax : pos_q + 1'b1;
        iso_q <= iso_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      hdr_q <= hdr_d;
      win_q <= win_d;
    end
  end

  isd_jpeg u_jpeg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .clr_i  (clr),
    .data_i (in_byte_q),
    .stat_o (jpeg_stat)
  );

  isd_tiff #(.PositionBits(PositionBits)) u_tiff (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .clr_i  (clr),
    .data_i (in_byte_q),
    .pos_i  (pos_q),
    .hdr_i  (hdr_d[7:0]),
    .stat_o (tiff_stat)
  );

  isd_judge #(.PositionBits(PositionBits)) u_judge (
    .hdr_i    (hdr_d),
    .pos_i    (pos_q),
    .jpeg_i   (jpeg_stat),
    .iso_i    (iso_d),
    .tiff_i   (tiff_stat),
    .found_o  (j_found),
    .format_o (j_format),
    .width_o  (j_width),
    .height_o (j_height)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (clr) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr) begin
      found_o  <= j_found;
      format_o <= j_format;
      width_o  <= j_width;
      height_o <= j_height;
    end
  end

  assign out_valid_o = out_valid_q;

  a_pos_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr |=> pos_q == '0)
    else $error("position not cleared after last beat");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !found_o |-> width_o == '0 && height_o == '0 &&
                                format_o == isd_pkg::FMT_PNG)
    else $error("result fields nonzero without a match");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty output register");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(clr))
    else $error("result appeared without a last beat");

endmodule
